>>> rtl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define RRTR_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition one edge implies a property at the next edge
`define RRTR_CHECK_NEXT(lbl, pre, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (prop)) \
    else $error(msg);

`endif

>>> rtl/rrtr_pkg.sv
// Package with constants, types and codes of the thread ring
`timescale 1ns / 1ps
`default_nettype none
package rrtr_pkg;

  localparam int POOL_SLOTS  = 16;
  localparam int HANDLE_BITS = 8;
  localparam int SLOT_BITS   = $clog2(POOL_SLOTS);
  localparam int COUNT_BITS  = $clog2(POOL_SLOTS + 1);

  typedef logic [SLOT_BITS-1:0]   slot_t;
  typedef logic [COUNT_BITS-1:0]  count_t;
  typedef logic [HANDLE_BITS-1:0] handle_t;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_NEXT = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_REFUSED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_LINK,
    S_HREAD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic  we;
    slot_t waddr;
    slot_t wdata;
    slot_t raddr;
  } link_req_t;

  typedef struct packed {
    logic    we;
    slot_t   waddr;
    handle_t wdata;
    slot_t   raddr;
  } hdl_req_t;

  typedef struct packed {
    status_t status;
    handle_t handle;
    count_t  count;
  } res_t;

endpackage
`default_nettype wire

>>> rtl/round_robin_thread_ring_top.sv
// Top level of the thread ring: link memories, sequencer and result register
//
//  channel   direction  handshake             payload
//  cfg       in         cfg_we                cfg_wdata (main thread handle)
//  in        in         in_valid / in_ready   in_opcode, in_thread_handle
//  out       out        out_valid / out_ready out_status, out_result_handle,
//                                             out_entry_count
//
// Each request passes EXEC and then DONE; a push that finds room adds LINK and
// an advance HREAD between them: each link memory has one write port and a
// registered read, so push writes in EXEC and LINK and advance reads again.
// After reset or a main-thread write, the INIT state rewrites slot 0 before a
// request is taken. A stalled result waits in the output register while the
// next request is accepted; the sequencer holds its own result until it drains.
`timescale 1ns / 1ps
`default_nettype none
module round_robin_thread_ring_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_opcode,
  input  wire logic [7:0] in_thread_handle,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_status,
  output logic [7:0]      out_result_handle,
  output logic [4:0]      out_entry_count
);

  rrtr_pkg::link_req_t next_req, prev_req;
  rrtr_pkg::hdl_req_t  hdl_req;
  rrtr_pkg::slot_t     next_rdata, prev_rdata;
  rrtr_pkg::handle_t   hdl_rdata;
  rrtr_pkg::res_t      res;
  logic                res_valid, res_ready;

  logic       out_valid_r;
  logic [1:0] out_status_r;
  logic [7:0] out_handle_r;
  logic [4:0] out_count_r;

  rrtr_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_thread_handle (in_thread_handle),
    .next_req         (next_req),
    .next_rdata       (next_rdata),
    .prev_req         (prev_req),
    .prev_rdata       (prev_rdata),
    .hdl_req          (hdl_req),
    .hdl_rdata        (hdl_rdata),
    .res_valid        (res_valid),
    .res_ready        (res_ready),
    .res              (res)
  );

  rrtr_ram #(.DEPTH(rrtr_pkg::POOL_SLOTS), .WIDTH(rrtr_pkg::SLOT_BITS)) u_next_ram (
    .clk   (clk),
    .we    (next_req.we),
    .waddr (next_req.waddr),
    .wdata (next_req.wdata),
    .raddr (next_req.raddr),
    .rdata (next_rdata)
  );

  rrtr_ram #(.DEPTH(rrtr_pkg::POOL_SLOTS), .WIDTH(rrtr_pkg::SLOT_BITS)) u_prev_ram (
    .clk   (clk),
    .we    (prev_req.we),
    .waddr (prev_req.waddr),
    .wdata (prev_req.wdata),
    .raddr (prev_req.raddr),
    .rdata (prev_rdata)
  );

  rrtr_ram #(.DEPTH(rrtr_pkg::POOL_SLOTS), .WIDTH(rrtr_pkg::HANDLE_BITS)) u_hdl_ram (
    .clk   (clk),
    .we    (hdl_req.we),
    .waddr (hdl_req.waddr),
    .wdata (hdl_req.wdata),
    .raddr (hdl_req.raddr),
    .rdata (hdl_rdata)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_status_r <= res.status;
      out_handle_r <= 8'(res.handle);
      out_count_r  <= 5'(res.count);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_result_handle = out_handle_r;
  assign out_entry_count   = out_count_r;

endmodule
`default_nettype wire

>>> rtl/rrtr_ram.sv
// Generic synchronous RAM, one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none
module rrtr_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 4
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/rrtr_ctrl.sv
// Sequencer of the thread ring: slot pool, cursor and link updates
`timescale 1ns / 1ps
`default_nettype none
module rrtr_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [7:0]           cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           in_opcode,
  input  wire logic [7:0]           in_thread_handle,
  output rrtr_pkg::link_req_t       next_req,
  input  wire rrtr_pkg::slot_t      next_rdata,
  output rrtr_pkg::link_req_t       prev_req,
  input  wire rrtr_pkg::slot_t      prev_rdata,
  output rrtr_pkg::hdl_req_t        hdl_req,
  input  wire rrtr_pkg::handle_t    hdl_rdata,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output rrtr_pkg::res_t            res
);

  rrtr_pkg::state_t  state_r, state_nxt;
  logic [1:0]        op_r, op_nxt;
  rrtr_pkg::handle_t hin_r, hin_nxt;
  rrtr_pkg::handle_t main_r;
  rrtr_pkg::slot_t   cur_r, cur_nxt;
  rrtr_pkg::count_t  size_r, size_nxt;
  rrtr_pkg::slot_t   free_r, free_nxt;
  rrtr_pkg::slot_t   succ_r, succ_nxt;
  logic [rrtr_pkg::POOL_SLOTS-1:0] in_use_r, in_use_nxt;
  rrtr_pkg::res_t    res_r, res_nxt;
  rrtr_pkg::slot_t   free_slot;
  logic              pool_full;

  always_comb begin
    free_slot = '0;
    for (int i = rrtr_pkg::POOL_SLOTS - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        free_slot = rrtr_pkg::SLOT_BITS'(i);
      end
    end
  end

  assign pool_full = &in_use_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rrtr_pkg::S_INIT: begin
        state_nxt = rrtr_pkg::S_IDLE;
      end
      rrtr_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = rrtr_pkg::S_EXEC;
        end
      end
      rrtr_pkg::S_EXEC: begin
        unique case (op_r)
          rrtr_pkg::OP_PUSH: state_nxt = pool_full ? rrtr_pkg::S_DONE : rrtr_pkg::S_LINK;
          rrtr_pkg::OP_NEXT: state_nxt = rrtr_pkg::S_HREAD;
          default:           state_nxt = rrtr_pkg::S_DONE;
        endcase
      end
      rrtr_pkg::S_LINK:  state_nxt = rrtr_pkg::S_DONE;
      rrtr_pkg::S_HREAD: state_nxt = rrtr_pkg::S_DONE;
      rrtr_pkg::S_DONE: begin
        if (res_ready) begin
          state_nxt = rrtr_pkg::S_IDLE;
        end
      end
      default: state_nxt = rrtr_pkg::S_INIT;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    next_req   = '{we: 1'b0, waddr: cur_r, wdata: cur_r, raddr: cur_r};
    prev_req   = '{we: 1'b0, waddr: cur_r, wdata: cur_r, raddr: cur_r};
    hdl_req    = '{we: 1'b0, waddr: cur_r, wdata: hin_r, raddr: cur_r};
    op_nxt     = op_r;
    hin_nxt    = hin_r;
    cur_nxt    = cur_r;
    size_nxt   = size_r;
    free_nxt   = free_r;
    succ_nxt   = succ_r;
    in_use_nxt = in_use_r;
    res_nxt    = res_r;
    unique case (state_r)
      rrtr_pkg::S_INIT: begin
        next_req = '{we: 1'b1, waddr: '0, wdata: '0, raddr: cur_r};
        prev_req = '{we: 1'b1, waddr: '0, wdata: '0, raddr: cur_r};
        hdl_req  = '{we: 1'b1, waddr: '0, wdata: main_r, raddr: cur_r};
      end
      rrtr_pkg::S_IDLE: begin
        in_ready = 1'b1;
        op_nxt   = in_opcode;
        hin_nxt  = rrtr_pkg::HANDLE_BITS'(in_thread_handle);
      end
      rrtr_pkg::S_EXEC: begin
        hdl_req.raddr = next_rdata;
        free_nxt      = free_slot;
        succ_nxt      = next_rdata;
        res_nxt       = '{status: rrtr_pkg::ST_OK, handle: '0, count: size_r};
        unique case (op_r)
          rrtr_pkg::OP_PUSH: begin
            if (pool_full) begin
              res_nxt.status = rrtr_pkg::ST_FULL;
            end else begin
              next_req.we    = 1'b1;
              next_req.waddr = cur_r;
              next_req.wdata = free_slot;
              prev_req.we    = 1'b1;
              prev_req.waddr = next_rdata;
              prev_req.wdata = free_slot;
              hdl_req.we     = 1'b1;
              hdl_req.waddr  = free_slot;
              hdl_req.wdata  = hin_r;
              in_use_nxt[free_slot] = 1'b1;
              size_nxt       = rrtr_pkg::COUNT_BITS'(size_r + 1'b1);
              res_nxt.count  = rrtr_pkg::COUNT_BITS'(size_r + 1'b1);
            end
          end
          rrtr_pkg::OP_POP: begin
            if (size_r <= rrtr_pkg::COUNT_BITS'(1)) begin
              res_nxt.status = rrtr_pkg::ST_REFUSED;
            end else begin
              next_req.we    = 1'b1;
              next_req.waddr = prev_rdata;
              next_req.wdata = next_rdata;
              prev_req.we    = 1'b1;
              prev_req.waddr = next_rdata;
              prev_req.wdata = prev_rdata;
              in_use_nxt[cur_r] = 1'b0;
              cur_nxt        = next_rdata;
              size_nxt       = rrtr_pkg::COUNT_BITS'(size_r - 1'b1);
              res_nxt.handle = hdl_rdata;
              res_nxt.count  = rrtr_pkg::COUNT_BITS'(size_r - 1'b1);
            end
          end
          rrtr_pkg::OP_NEXT: begin
            cur_nxt = next_rdata;
          end
          default: begin
          end
        endcase
      end
      rrtr_pkg::S_LINK: begin
        next_req = '{we: 1'b1, waddr: free_r, wdata: succ_r, raddr: cur_r};
        prev_req = '{we: 1'b1, waddr: free_r, wdata: cur_r, raddr: cur_r};
      end
      rrtr_pkg::S_HREAD: begin
        res_nxt = '{status: rrtr_pkg::ST_OK, handle: hdl_rdata, count: size_r};
      end
      rrtr_pkg::S_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= rrtr_pkg::S_INIT;
      main_r   <= '0;
      cur_r    <= '0;
      size_r   <= rrtr_pkg::COUNT_BITS'(1);
      in_use_r <= rrtr_pkg::POOL_SLOTS'(1);
    end else if (cfg_we) begin
      state_r  <= rrtr_pkg::S_INIT;
      main_r   <= rrtr_pkg::HANDLE_BITS'(cfg_wdata);
      cur_r    <= '0;
      size_r   <= rrtr_pkg::COUNT_BITS'(1);
      in_use_r <= rrtr_pkg::POOL_SLOTS'(1);
    end else begin
      state_r  <= state_nxt;
      cur_r    <= cur_nxt;
      size_r   <= size_nxt;
      in_use_r <= in_use_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    hin_r  <= hin_nxt;
    free_r <= free_nxt;
    succ_r <= succ_nxt;
    res_r  <= res_nxt;
  end

endmodule
`default_nettype wire

>>> rtl/rrtr_checker.sv
// Port checker of the thread ring and its bind to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rrtr_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       cfg_we,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_status,
  input wire logic [7:0] out_result_handle,
  input wire logic [4:0] out_entry_count
);

  `RRTR_CHECK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_result_handle) && $stable(out_entry_count), "stalled result changed")
  `RRTR_CHECK(a_refused_single, (out_valid && out_status == 2'(rrtr_pkg::ST_REFUSED)) |-> (out_entry_count == 5'd1 && out_result_handle == 8'd0), "refused pop with more than one entry")
  `RRTR_CHECK(a_full_count, (out_valid && out_status == 2'(rrtr_pkg::ST_FULL)) |-> (out_entry_count == 5'(rrtr_pkg::POOL_SLOTS) && out_result_handle == 8'd0), "pool full below capacity")
  `RRTR_CHECK_NEXT(a_restart_busy, cfg_we, !in_ready, "request taken during ring restart")

endmodule

bind round_robin_thread_ring_top rrtr_checker u_rrtr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .cfg_we            (cfg_we),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_status        (out_status),
  .out_result_handle (out_result_handle),
  .out_entry_count   (out_entry_count)
);
`default_nettype wire
